>>> hdl/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// ohlc_pkg
// Shared widths, codes, item types and the bar-interval table for the
// OHLCV bar aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package ohlc_pkg;

   localparam int TIME_W  = 32;
   localparam int PRICE_W = 32;
   localparam int QTY_W   = 32;
   localparam int VOL_W   = 48;
   localparam int CNT_W   = 32;
   localparam int IVL_W   = 2;

   localparam int REQ_DATA_W = TIME_W + PRICE_W + QTY_W;
   localparam int RSP_DATA_W = 2 * TIME_W + 4 * PRICE_W + VOL_W + CNT_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Register index within the CSR map (byte address 4 * index)
   localparam logic [CSR_AW-3:0] CSR_IDX_INTERVAL = 1'b0;

   // Interval select codes
   localparam logic [IVL_W-1:0] IVL_SECOND = 2'd0;
   localparam logic [IVL_W-1:0] IVL_MINUTE = 2'd1;
   localparam logic [IVL_W-1:0] IVL_HOUR   = 2'd2;
   localparam logic [IVL_W-1:0] IVL_DAY    = 2'd3;
   localparam logic [IVL_W-1:0] IVL_RESET  = IVL_MINUTE;

   localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Input command codes
   localparam logic CMD_TRADE = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic               flush;
      logic [TIME_W-1:0]  trade_time;
      logic [TIME_W-1:0]  close_time;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   quantity;
   } ohlc_item_type;

   typedef struct packed {
      logic [TIME_W-1:0]  open_time;
      logic [TIME_W-1:0]  close_time;
      logic [PRICE_W-1:0] open_price;
      logic [PRICE_W-1:0] high_price;
      logic [PRICE_W-1:0] low_price;
      logic [PRICE_W-1:0] close_price;
      logic [VOL_W-1:0]   volume;
      logic [CNT_W-1:0]   count;
   } ohlc_bar_type;

   function automatic logic [TIME_W-1:0] interval_seconds(input logic [IVL_W-1:0] sel);
      logic [TIME_W-1:0] secs;
      unique case (sel)
         IVL_SECOND: secs = TIME_W'(1);
         IVL_MINUTE: secs = TIME_W'(60);
         IVL_HOUR:   secs = TIME_W'(60 * 60);
         IVL_DAY:    secs = TIME_W'(24 * 60 * 60);
      endcase
      return secs;
   endfunction

endpackage

`default_nettype wire

>>> hdl/ohlc_front.sv
// ----------------------------------------------------------------------------
// ohlc_front
// Interval register with its CSR port; decodes incoming transactions and
// precomputes the close time a trade would give a new bar.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ohlc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ohlc_pkg::CSR_AW-1:0]     csr_paddr,
   input  wire logic [ohlc_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [ohlc_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready,
   output logic                                 push_valid,
   input  wire logic                            push_ready,
   output ohlc_pkg::ohlc_item_type              push_item
);

   logic [ohlc_pkg::IVL_W-1:0] interval_ff;
   logic [ohlc_pkg::IVL_W-1:0] interval_in;
   logic                       csr_write;
   logic                       csr_hit;
   logic [ohlc_pkg::TIME_W-1:0] trade_time;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[ohlc_pkg::CSR_AW-1:2] == ohlc_pkg::CSR_IDX_INTERVAL);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      interval_in = interval_ff;
      if (csr_write && csr_hit) begin
         interval_in = csr_pwdata[ohlc_pkg::IVL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= ohlc_pkg::IVL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = ohlc_pkg::CSR_DW'(interval_ff);
      end
   end

   // Classify and pass into the queue; close time is open time plus interval
   assign trade_time = req_tdata[ohlc_pkg::TIME_W-1:0];

   assign push_valid            = req_tvalid;
   assign req_tready            = push_ready;
   assign push_item.flush       = (req_tuser == ohlc_pkg::CMD_FLUSH);
   assign push_item.trade_time  = trade_time;
   assign push_item.close_time  = trade_time + ohlc_pkg::interval_seconds(interval_ff);
   assign push_item.price       =
      req_tdata[ohlc_pkg::TIME_W +: ohlc_pkg::PRICE_W];
   assign push_item.quantity    =
      req_tdata[ohlc_pkg::TIME_W + ohlc_pkg::PRICE_W +: ohlc_pkg::QTY_W];

endmodule

`default_nettype wire

>>> hdl/ohlc_queue.sv
// ----------------------------------------------------------------------------
// ohlc_queue
// Short flip-flop FIFO between the decode front and the bar back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   input  wire ohlc_pkg::ohlc_item_type push_item,
   output logic                         pop_valid,
   input  wire logic                    pop_ready,
   output ohlc_pkg::ohlc_item_type      pop_item
);

   ohlc_pkg::ohlc_item_type          entry_ff [ohlc_pkg::QUEUE_DEPTH];
   logic [ohlc_pkg::QUEUE_AW-1:0]    wr_ptr_ff;
   logic [ohlc_pkg::QUEUE_AW-1:0]    wr_ptr_in;
   logic [ohlc_pkg::QUEUE_AW-1:0]    rd_ptr_ff;
   logic [ohlc_pkg::QUEUE_AW-1:0]    rd_ptr_in;
   logic [ohlc_pkg::QUEUE_CW-1:0]    count_ff;
   logic [ohlc_pkg::QUEUE_CW-1:0]    count_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = (count_ff != ohlc_pkg::QUEUE_CW'(ohlc_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ohlc_back.sv
// ----------------------------------------------------------------------------
// ohlc_back
// Open bar state: close test, high/low/close update, saturating volume and
// count, and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   output logic                         pop_ready,
   input  wire ohlc_pkg::ohlc_item_type pop_item,
   output logic                         bar_valid,
   input  wire logic                    bar_ready,
   output ohlc_pkg::ohlc_bar_type       bar_out
);

   logic                       active_ff;
   logic                       active_in;
   ohlc_pkg::ohlc_bar_type     bar_ff;
   ohlc_pkg::ohlc_bar_type     bar_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   ohlc_pkg::ohlc_bar_type     out_ff;
   logic                       do_pop;
   logic                       emit;
   logic                       closes;
   logic [ohlc_pkg::TIME_W-1:0] time_diff;
   logic [ohlc_pkg::VOL_W:0]   vol_sum;

   assign pop_ready = !out_valid_ff || bar_ready;
   assign do_pop    = pop_valid && pop_ready;

   // Trade at or after close: wrapped difference is non-negative
   assign time_diff = pop_item.trade_time - bar_ff.close_time;
   assign closes    = !time_diff[ohlc_pkg::TIME_W-1];
   assign vol_sum   = {1'b0, bar_ff.volume} +
                      (ohlc_pkg::VOL_W + 1)'(pop_item.quantity);

   always_comb begin
      active_in = active_ff;
      bar_in    = bar_ff;
      emit      = 1'b0;
      if (do_pop) begin
         priority if (pop_item.flush) begin
            emit      = active_ff;
            active_in = 1'b0;
         end else if (!active_ff || closes) begin
            emit              = active_ff;
            active_in         = 1'b1;
            bar_in.open_time  = pop_item.trade_time;
            bar_in.close_time = pop_item.close_time;
            bar_in.open_price = pop_item.price;
            bar_in.high_price = pop_item.price;
            bar_in.low_price  = pop_item.price;
            bar_in.close_price = pop_item.price;
            bar_in.volume     = ohlc_pkg::VOL_W'(pop_item.quantity);
            bar_in.count      = ohlc_pkg::CNT_W'(1);
         end else begin
            if (pop_item.price > bar_ff.high_price) begin
               bar_in.high_price = pop_item.price;
            end
            if (pop_item.price < bar_ff.low_price) begin
               bar_in.low_price = pop_item.price;
            end
            bar_in.close_price = pop_item.price;
            bar_in.volume = vol_sum[ohlc_pkg::VOL_W] ? ohlc_pkg::VOL_MAX
                                                     : vol_sum[ohlc_pkg::VOL_W-1:0];
            if (bar_ff.count != ohlc_pkg::CNT_MAX) begin
               bar_in.count = bar_ff.count + 1'b1;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (bar_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_ff <= bar_in;
      if (emit) begin
         out_ff <= bar_ff;
      end
   end

   assign bar_valid = out_valid_ff;
   assign bar_out   = out_ff;

endmodule

`default_nettype wire

>>> hdl/ohlc_bar_aggregator.sv
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator
// Builds open-high-low-close-volume bars from a time-ordered trade stream.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one transaction per trade or flush command. tuser
//   selects the kind (0 trade, 1 flush); tdata holds trade_time, price_cents
//   and quantity. A trade at or after the open bar's close time finishes that
//   bar and opens a new one; a flush finishes the open bar, if any.
//   rsp channel carries one finished bar per transaction.
//   csr port holds interval_select at byte address 0 (0 second, 1 minute,
//   2 hour, 3 day); write it only while the block is idle.
// Timing:
//   Throughput is one transaction per cycle while rsp is not stalled. A finished
//   bar reaches rsp through the decode front and queue, then through the bar
//   update and result register.
// Reset:
//   Interval returns to one minute, no bar is open, queue and result are empty.
// Stall:
//   A stalled rsp holds the result register and the back end; the 4-entry
//   queue absorbs further transactions, then req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_bar_aggregator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input transactions
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] trade_time, [63:32] price_cents, [95:64] quantity
   input  wire logic [ohlc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] cmd
   input  wire logic                            req_tuser,
   // Finished bars
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [31:0] bar_open_time, [63:32] bar_close_time, [95:64] open_price,
   // [127:96] high_price, [159:128] low_price, [191:160] close_price,
   // [239:192] bar_volume, [271:240] trade_count
   output logic [ohlc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ohlc_pkg::CSR_AW-1:0]     csr_paddr,
   input  wire logic [ohlc_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [ohlc_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready
);

   logic                    push_valid;
   logic                    push_ready;
   ohlc_pkg::ohlc_item_type push_item;
   logic                    pop_valid;
   logic                    pop_ready;
   ohlc_pkg::ohlc_item_type pop_item;
   ohlc_pkg::ohlc_bar_type  bar_out;

   // Decode transactions, hold the interval register
   ohlc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   // Decouple front and back so each side stalls on its own
   ohlc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Update the open bar and register finished bars
   ohlc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .bar_valid (rsp_tvalid),
      .bar_ready (rsp_tready),
      .bar_out   (bar_out)
   );

   // Pack the first field into the lowest bits
   assign rsp_tdata = {bar_out.count, bar_out.volume, bar_out.close_price,
                       bar_out.low_price, bar_out.high_price, bar_out.open_price,
                       bar_out.close_time, bar_out.open_time};

endmodule

`default_nettype wire
